>>> rtl/core/ssdp_pkg.sv
package ssdp_pkg;

    // Input command kinds
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_MOVE = 2'd1;
    localparam logic [1:0] CMD_GOTO = 2'd2;
    localparam logic [1:0] CMD_HOME = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_BUSY  = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_HALF = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_HALF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_EN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_POS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_POS   = 3'd4;

    localparam int unsigned HALF_W = 16;
    localparam int unsigned OUT_POS_W = 32;

    typedef struct packed {
        logic [1:0]         command;
        logic [30:0]        step_count;
        logic               move_up;
        logic signed [31:0] target;
        logic               limit_switch;
    } item_t;

    typedef struct packed {
        logic [1:0]           status;
        logic                 step_level;
        logic                 dir_level;
        logic [OUT_POS_W-1:0] position;
        logic                 busy_res;
    } result_t;

endpackage

>>> rtl/core/stepper_step_dir_positioner.sv
// Step/direction positioner for a stepper motor driver.
// Slave stream: one transfer per item. tuser carries the command (tick, relative
// move, absolute go-to, home); tdata carries step count, direction, target and
// the limit switch level sampled with ticks. Send one tick transfer per
// microsecond; commands arrive interleaved with ticks.
// Master stream: exactly one result transfer per input item, in order, carrying
// status, step and direction levels, the current position and the busy flag.
// Configuration: write cfg_data to register cfg_index while the block is idle
// (half periods, homing enable, go-to limits).
// Flow: an accepted item lands in the input register and passes the update logic once
// the output side has room; its result is registered in the output register and shows on
// m_tvalid. Throughput is one item per clock while the output side has room, set by the
// single pass of update logic between the input register and the output register.
// Reset clears position, counters, pulse and direction outputs, the run state
// and all configuration registers; no output transfer is pending afterward.
// When the receiver stalls, the output register plus a skid stage absorb
// results; s_tready drops only once both are full and the input register holds.
module stepper_step_dir_positioner #(
    parameter int POSITION_WIDTH = 32,
    parameter int DELAY_WIDTH    = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [ssdp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssdp_pkg::CFG_DATA_W-1:0] cfg_data,
    // Input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [30:0] step_count, [31] move_up, [63:32] target, [64] limit_switch, [71:65] zero
    input  logic [71:0]                     s_tdata,
    // [1:0] command
    input  logic [1:0]                      s_tuser,
    // Result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] status, [2] step_level, [3] dir_level, [35:4] position, [36] busy_res,
    // [39:37] zero
    output logic [39:0]                     m_tdata
);

    logic              in_valid_reg;
    ssdp_pkg::item_t   in_item_reg;
    logic              advance;
    logic              room;
    ssdp_pkg::result_t result;
    ssdp_pkg::result_t out_data;

    // Advance the held item through the update logic whenever the output side has space
    assign advance  = in_valid_reg && room;
    assign s_tready = !in_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.command      <= s_tuser;
            in_item_reg.step_count   <= s_tdata[30:0];
            in_item_reg.move_up      <= s_tdata[31];
            in_item_reg.target       <= signed'(s_tdata[63:32]);
            in_item_reg.limit_switch <= s_tdata[64];
        end
    end

    ssdp_core #(
        .POSITION_WIDTH (POSITION_WIDTH),
        .DELAY_WIDTH    (DELAY_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (advance),
        .item       (in_item_reg),
        .result     (result)
    );

    ssdp_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .push_data (result),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {3'b000, out_data.busy_res, out_data.position, out_data.dir_level,
                      out_data.step_level, out_data.status};

endmodule

>>> rtl/core/ssdp_core.sv
module ssdp_core #(
    parameter int POSITION_WIDTH = 32,
    parameter int DELAY_WIDTH    = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ssdp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ssdp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                item_valid,
    input  ssdp_pkg::item_t                     item,
    output ssdp_pkg::result_t                   result
);

    localparam int CMP_W  = ((POSITION_WIDTH > 32) ? POSITION_WIDTH : 32) + 1;
    localparam int HEXT_W = (DELAY_WIDTH > 16) ? DELAY_WIDTH : 16;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_MOVE = 2'd1;
    localparam logic [1:0] MODE_HOME = 2'd2;

    // Configuration registers
    logic [ssdp_pkg::HALF_W-1:0] step_half_reg;
    logic [ssdp_pkg::HALF_W-1:0] home_half_reg;
    logic                        home_en_reg;
    logic signed [31:0]          min_pos_reg;
    logic signed [31:0]          max_pos_reg;

    // Run state
    logic [POSITION_WIDTH-1:0] pos_reg,   pos_next;
    logic [CMP_W-1:0]          left_reg,  left_next;
    logic [DELAY_WIDTH-1:0]    cnt_reg,   cnt_next;
    logic                      pulse_reg, pulse_next;
    logic                      dir_reg,   dir_next;
    logic [1:0]                mode_reg,  mode_next;
    logic [1:0]                status;

    logic [HEXT_W-1:0]       half_ext;
    logic [DELAY_WIDTH-1:0]  half_raw;
    logic [DELAY_WIDTH-1:0]  half_eff;
    logic [DELAY_WIDTH-1:0]  cnt_inc;
    logic [CMP_W-1:0]        left_dec;
    logic signed [CMP_W-1:0] tgt_s, pos_s, min_s, max_s;
    logic [CMP_W-1:0]        dist_up, dist_down;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_half_reg <= '0;
            home_half_reg <= '0;
            home_en_reg   <= 1'b0;
            min_pos_reg   <= '0;
            max_pos_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ssdp_pkg::REG_STEP_HALF: step_half_reg <= cfg_data[ssdp_pkg::HALF_W-1:0];
                ssdp_pkg::REG_HOME_HALF: home_half_reg <= cfg_data[ssdp_pkg::HALF_W-1:0];
                ssdp_pkg::REG_HOME_EN:   home_en_reg   <= cfg_data[0];
                ssdp_pkg::REG_MIN_POS:   min_pos_reg   <= signed'(cfg_data[31:0]);
                ssdp_pkg::REG_MAX_POS:   max_pos_reg   <= signed'(cfg_data[31:0]);
                default: ;
            endcase
        end
    end

    // Effective half period: live register of the running mode, zero acts as one
    always_comb
    begin
        half_ext = (mode_reg == MODE_MOVE) ? HEXT_W'(step_half_reg) : HEXT_W'(home_half_reg);
        half_raw = half_ext[DELAY_WIDTH-1:0];
        half_eff = (half_raw == '0) ? DELAY_WIDTH'(1) : half_raw;
    end

    assign cnt_inc   = cnt_reg + DELAY_WIDTH'(1);
    assign left_dec  = left_reg - CMP_W'(1);
    assign tgt_s     = CMP_W'(item.target);
    assign pos_s     = CMP_W'(signed'(pos_reg));
    assign min_s     = CMP_W'(min_pos_reg);
    assign max_s     = CMP_W'(max_pos_reg);
    assign dist_up   = tgt_s - pos_s;
    assign dist_down = pos_s - tgt_s;

    always_comb
    begin
        pos_next   = pos_reg;
        left_next  = left_reg;
        cnt_next   = cnt_reg;
        pulse_next = pulse_reg;
        dir_next   = dir_reg;
        mode_next  = mode_reg;
        status     = ssdp_pkg::STAT_OK;

        if (item.command == ssdp_pkg::CMD_TICK)
        begin
            if (mode_reg != MODE_IDLE)
            begin
                if (cnt_inc < half_eff)
                begin
                    cnt_next = cnt_inc;
                end
                else
                begin
                    cnt_next = '0;
                    if (pulse_reg)
                    begin
                        pulse_next = 1'b0;
                    end
                    else if (mode_reg == MODE_MOVE)
                    begin
                        // Step complete: count position, then start the next one if steps remain
                        pos_next  = dir_reg ? pos_reg - POSITION_WIDTH'(1)
                                            : pos_reg + POSITION_WIDTH'(1);
                        left_next = left_dec;
                        if (left_dec == '0)
                            mode_next = MODE_IDLE;
                        else
                            pulse_next = 1'b1;
                    end
                    else if (!item.limit_switch)
                    begin
                        pos_next  = '0;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        pulse_next = 1'b1;
                    end
                end
            end
        end
        else if (mode_reg != MODE_IDLE)
        begin
            status = ssdp_pkg::STAT_BUSY;
        end
        else if (item.command == ssdp_pkg::CMD_MOVE)
        begin
            dir_next  = !item.move_up;
            left_next = CMP_W'(item.step_count);
            cnt_next  = '0;
            if (item.step_count != '0)
            begin
                mode_next  = MODE_MOVE;
                pulse_next = 1'b1;
            end
        end
        else if (item.command == ssdp_pkg::CMD_GOTO)
        begin
            if (tgt_s < min_s || tgt_s > max_s)
            begin
                status = ssdp_pkg::STAT_RANGE;
            end
            else if (tgt_s > pos_s)
            begin
                dir_next   = 1'b0;
                left_next  = dist_up;
                cnt_next   = '0;
                mode_next  = MODE_MOVE;
                pulse_next = 1'b1;
            end
            else if (tgt_s < pos_s)
            begin
                dir_next   = 1'b1;
                left_next  = dist_down;
                cnt_next   = '0;
                mode_next  = MODE_MOVE;
                pulse_next = 1'b1;
            end
        end
        else
        begin
            dir_next = 1'b1;
            cnt_next = '0;
            if (home_en_reg && item.limit_switch)
            begin
                mode_next  = MODE_HOME;
                pulse_next = 1'b1;
            end
            else
            begin
                pos_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            left_reg  <= '0;
            cnt_reg   <= '0;
            pulse_reg <= 1'b0;
            dir_reg   <= 1'b0;
            mode_reg  <= MODE_IDLE;
        end
        else if (item_valid)
        begin
            pos_reg   <= pos_next;
            left_reg  <= left_next;
            cnt_reg   <= cnt_next;
            pulse_reg <= pulse_next;
            dir_reg   <= dir_next;
            mode_reg  <= mode_next;
        end
    end

    always_comb
    begin
        result.status     = status;
        result.step_level = pulse_next;
        result.dir_level  = dir_next;
        result.position   = ssdp_pkg::OUT_POS_W'(pos_next);
        result.busy_res   = (mode_next != MODE_IDLE);
    end

endmodule

>>> rtl/core/ssdp_obuf.sv
module ssdp_obuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ssdp_pkg::result_t push_data,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output ssdp_pkg::result_t out_data
);

    logic              head_valid_reg;
    logic              skid_valid_reg;
    ssdp_pkg::result_t head_reg;
    ssdp_pkg::result_t skid_reg;
    logic              pop;

    assign pop       = head_valid_reg && out_ready;
    assign room      = !skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // Drain the skid stage into the head on a taken transfer
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!head_valid_reg || pop)
                head_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            head_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                head_reg <= skid_reg;
        end
        else if (push)
        begin
            if (!head_valid_reg || pop)
                head_reg <= push_data;
            else
                skid_reg <= push_data;
        end
    end

endmodule

>>> sim/stepper_motion_checker.sv
module stepper_motion_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ssdp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ssdp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    // [30:0] step_count, [31] move_up, [63:32] target, [64] limit_switch, [71:65] zero
    input  logic [71:0]                       s_tdata,
    // [1:0] command
    input  logic [1:0]                        s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] status, [2] step_level, [3] dir_level, [35:4] position, [36] busy_res,
    // [39:37] zero
    input  logic [39:0]                       m_tdata,
    output int                                mismatch_count,
    output int                                reports_due
);

    typedef enum logic [1:0] {
        MOTOR_IDLE,
        MOTOR_MOVE,
        MOTOR_HOME
    } motor_mode_e;

    // Register copies
    logic [15:0]        step_half;
    logic [15:0]        home_half;
    logic               home_en;
    logic signed [31:0] min_pos;
    logic signed [31:0] max_pos;

    // Motor state
    logic signed [31:0] position;
    logic [31:0]        steps_left;
    logic [15:0]        half_cnt;
    logic               pulse;
    logic               dir_down;
    motor_mode_e        mode;

    ssdp_pkg::result_t  pending_reports[$];
    int                 fails;

    task automatic count_tick(input logic sw);
        logic [15:0] half;
        if (mode == MOTOR_IDLE)
            return;
        half = (mode == MOTOR_MOVE) ? step_half : home_half;
        if (half == 16'd0)
            half = 16'd1;
        half_cnt = half_cnt + 16'd1;
        if (half_cnt < half)
            return;
        half_cnt = '0;
        if (pulse)
        begin
            pulse = 1'b0;
            return;
        end
        if (mode == MOTOR_MOVE)
        begin
            position = dir_down ? position - 32'sd1 : position + 32'sd1;
            steps_left = steps_left - 32'd1;
            if (steps_left == 32'd0)
                mode = MOTOR_IDLE;
            else
                pulse = 1'b1;
        end
        else if (!sw)
        begin
            position = '0;
            mode = MOTOR_IDLE;
        end
        else
            pulse = 1'b1;
    endtask

    task automatic begin_move(input logic [31:0] n, input logic down);
        dir_down = down;
        steps_left = n;
        half_cnt = '0;
        if (n != 32'd0)
        begin
            mode = MOTOR_MOVE;
            pulse = 1'b1;
        end
    endtask

    // Apply one transfer to the motor copy and return the report it should produce.
    task automatic motor_response(input ssdp_pkg::item_t it, output ssdp_pkg::result_t rep);
        rep.status = ssdp_pkg::STAT_OK;
        if (it.command == ssdp_pkg::CMD_TICK)
            count_tick(it.limit_switch);
        else if (mode != MOTOR_IDLE)
            rep.status = ssdp_pkg::STAT_BUSY;
        else
        begin
            unique case (it.command)
                ssdp_pkg::CMD_MOVE: begin_move({1'b0, it.step_count}, !it.move_up);
                ssdp_pkg::CMD_GOTO:
                begin
                    if (it.target < min_pos || it.target > max_pos)
                        rep.status = ssdp_pkg::STAT_RANGE;
                    else if (it.target > position)
                        begin_move(it.target - position, 1'b0);
                    else if (it.target < position)
                        begin_move(position - it.target, 1'b1);
                end
                default:
                begin
                    dir_down = 1'b1;
                    half_cnt = '0;
                    if (home_en && it.limit_switch)
                    begin
                        mode = MOTOR_HOME;
                        pulse = 1'b1;
                    end
                    else
                        position = '0;
                end
            endcase
        end
        rep.step_level = pulse;
        rep.dir_level  = dir_down;
        rep.position   = position;
        rep.busy_res   = (mode != MOTOR_IDLE);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ssdp_pkg::item_t   it;
        ssdp_pkg::result_t want;
        ssdp_pkg::result_t got;
        if (!rst_n)
        begin
            step_half  = '0;
            home_half  = '0;
            home_en    = 1'b0;
            min_pos    = '0;
            max_pos    = '0;
            position   = '0;
            steps_left = '0;
            half_cnt   = '0;
            pulse      = 1'b0;
            dir_down   = 1'b0;
            mode       = MOTOR_IDLE;
            fails      = 0;
            pending_reports.delete();
            mismatch_count <= 0;
            reports_due    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ssdp_pkg::REG_STEP_HALF: step_half = cfg_data[15:0];
                    ssdp_pkg::REG_HOME_HALF: home_half = cfg_data[15:0];
                    ssdp_pkg::REG_HOME_EN:   home_en   = cfg_data[0];
                    ssdp_pkg::REG_MIN_POS:   min_pos   = cfg_data;
                    ssdp_pkg::REG_MAX_POS:   max_pos   = cfg_data;
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                got.status     = m_tdata[1:0];
                got.step_level = m_tdata[2];
                got.dir_level  = m_tdata[3];
                got.position   = m_tdata[35:4];
                got.busy_res   = m_tdata[36];
                if (pending_reports.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result transfer: status %0d pos %0d",
                                 got.status, $signed(got.position));
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (got !== want)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display({"result mismatch: expected status %0d step %b dir %b ",
                                      "pos %0d busy %b, got status %0d step %b dir %b ",
                                      "pos %0d busy %b"},
                                     want.status, want.step_level, want.dir_level,
                                     $signed(want.position), want.busy_res,
                                     got.status, got.step_level, got.dir_level,
                                     $signed(got.position), got.busy_res);
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                it.command      = s_tuser;
                it.step_count   = s_tdata[30:0];
                it.move_up      = s_tdata[31];
                it.target       = s_tdata[63:32];
                it.limit_switch = s_tdata[64];
                motor_response(it, want);
                pending_reports.push_back(want);
            end

            mismatch_count <= fails;
            reports_due    <= pending_reports.size();
        end
    end

endmodule

>>> sim/tb_stepper_step_dir_positioner.sv
module tb_stepper_step_dir_positioner;

    // Quiet cycles (no transfer on either side) tolerated before giving up
    localparam int QUIET_LIMIT = 5000;
    // Length of the long receiver hold-off
    localparam int HOLDOFF_CYCLES = 300;
    localparam int PHASE_ITEMS = 200;
    // Ticks allowed for the motor to come to rest before giving up
    localparam int SETTLE_LIMIT = 4096;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [ssdp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ssdp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    // [30:0] step_count, [31] move_up, [63:32] target, [64] limit_switch, [71:65] zero
    logic [71:0]                     s_tdata = '0;
    // [1:0] command
    logic [1:0]                      s_tuser = ssdp_pkg::CMD_TICK;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // [1:0] status, [2] step_level, [3] dir_level, [35:4] position, [36] busy_res,
    // [39:37] zero
    logic [39:0]                     m_tdata;

    int                              mismatch_count;
    int                              reports_due;

    // Busy flag of the most recent result transfer, used to decide when the motor is idle
    logic                            last_busy = 1'b0;
    // Suppress idling on both sides while set
    logic                            calm = 1'b0;
    // Go-to target window for random commands
    int                              lo_lim;
    int                              hi_lim;
    logic                            wide_targets;
    int                              quiet = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    stepper_step_dir_positioner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    stepper_motion_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .reports_due    (reports_due)
    );

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            last_busy <= m_tdata[36];
    end

    // Watchdog: abort when nothing moves on either stream for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
        begin
            quiet <= quiet + 1;
            if (quiet == QUIET_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Result sink: random backpressure, plus long hold-offs to fill the pipeline
    initial
    begin : sink
        int cycles;
        cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles == 1500 || cycles == 3200)
            begin
                // Hold off while the sender keeps offering so s_tready has to drop
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end
            m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 34);
        end
    end

    // Offer one item and hold it until the transfer completes
    task automatic send_item(input logic [1:0] cmd, input logic [30:0] cnt, input logic up,
                             input logic [31:0] tgt, input logic sw);
        while (!calm && $urandom_range(0, 99) < 34)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, sw, tgt, up, cnt};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Tick with garbage in the ignored fields; switch reads home about a quarter of the time
    task automatic send_tick(input logic sw);
        send_item(ssdp_pkg::CMD_TICK, 31'($urandom()), 1'($urandom_range(0, 1)), $urandom(),
                  sw);
    endtask

    // Random command with small step counts and targets around the go-to window, or any target when wide_targets is set
    task automatic send_command(input logic [1:0] cmd);
        logic [31:0] tgt;
        if (wide_targets)
            tgt = $urandom();
        else
            tgt = lo_lim - 4 + int'($urandom_range(0, hi_lim - lo_lim + 8));
        send_item(cmd, 31'($urandom_range(0, 9)), 1'($urandom_range(0, 1)), tgt,
                  $urandom_range(0, 99) < 70);
    endtask

    // Stop offering and wait until every result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (reports_due != 0)
            @(posedge clk);
    endtask

    // Drain, then tick with the switch at home until the motor reports idle
    task automatic settle();
        int ticks;
        ticks = 0;
        drain();
        while (last_busy)
        begin
            if (ticks >= SETTLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            repeat (16) send_item(ssdp_pkg::CMD_TICK, '0, 1'b0, '0, 1'b0);
            ticks += 16;
            drain();
        end
    endtask

    // Write all five registers; call only while the motor is idle and drained
    task automatic load_settings(input logic [15:0] step_h, input logic [15:0] home_h,
                                 input logic en, input logic signed [31:0] mn,
                                 input logic signed [31:0] mx);
        cfg_we <= 1'b1;
        cfg_index <= ssdp_pkg::REG_STEP_HALF;
        cfg_data  <= {16'd0, step_h};
        @(posedge clk);
        cfg_index <= ssdp_pkg::REG_HOME_HALF;
        cfg_data  <= {16'd0, home_h};
        @(posedge clk);
        cfg_index <= ssdp_pkg::REG_HOME_EN;
        cfg_data  <= {31'd0, en};
        @(posedge clk);
        cfg_index <= ssdp_pkg::REG_MIN_POS;
        cfg_data  <= mn;
        @(posedge clk);
        cfg_index <= ssdp_pkg::REG_MAX_POS;
        cfg_data  <= mx;
        @(posedge clk);
        cfg_we <= 1'b0;
        lo_lim = mn;
        hi_lim = mx;
    endtask

    // Command/tick-burst sequences, with stray commands dropped into the bursts
    task automatic random_traffic(input int n_items);
        int sent;
        int burst;
        sent = 0;
        while (sent < n_items)
        begin
            send_command(2'($urandom_range(1, 3)));
            sent++;
            burst = $urandom_range(0, 40);
            repeat (burst)
            begin
                if ($urandom_range(0, 99) < 8)
                    send_command(2'($urandom_range(1, 3)));
                else
                    send_tick($urandom_range(0, 99) >= 25);
                sent++;
            end
        end
    endtask

    initial
    begin : stimulus
        wide_targets = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Homing disabled, half period 0 behaves as one tick
        load_settings(16'd0, 16'd0, 1'b0, -32'sd100, 32'sd100);
        send_item(ssdp_pkg::CMD_MOVE, 31'd0, 1'b1, '0, 1'b1);      // zero length up
        send_item(ssdp_pkg::CMD_MOVE, 31'd0, 1'b0, '0, 1'b1);      // zero length down sets dir
        send_item(ssdp_pkg::CMD_GOTO, '0, 1'b0, 32'sd0, 1'b1);     // go-to current position
        send_item(ssdp_pkg::CMD_GOTO, '0, 1'b0, 32'sd101, 1'b1);   // above max
        send_item(ssdp_pkg::CMD_GOTO, '0, 1'b0, -32'sd101, 1'b1);  // below min
        send_item(ssdp_pkg::CMD_MOVE, 31'd2, 1'b1, '0, 1'b1);
        send_item(ssdp_pkg::CMD_MOVE, 31'd5, 1'b1, '0, 1'b1);      // rejected, busy
        send_item(ssdp_pkg::CMD_GOTO, '0, 1'b0, 32'sd0, 1'b1);     // rejected, busy
        send_item(ssdp_pkg::CMD_HOME, '0, 1'b0, '0, 1'b1);         // rejected, busy
        repeat (4) send_item(ssdp_pkg::CMD_TICK, '0, 1'b0, '0, 1'b1);
        send_item(ssdp_pkg::CMD_HOME, '0, 1'b0, '0, 1'b1);         // homing off: zero at once
        settle();

        // Homing enabled: switch already home, then a real homing run
        load_settings(16'd0, 16'd0, 1'b1, -32'sd100, 32'sd100);
        send_item(ssdp_pkg::CMD_HOME, '0, 1'b0, '0, 1'b0);
        send_item(ssdp_pkg::CMD_HOME, '0, 1'b0, '0, 1'b1);
        send_item(ssdp_pkg::CMD_TICK, '0, 1'b0, '0, 1'b1);
        send_item(ssdp_pkg::CMD_TICK, '0, 1'b0, '0, 1'b1);
        send_item(ssdp_pkg::CMD_TICK, '0, 1'b0, '0, 1'b0);
        send_item(ssdp_pkg::CMD_TICK, '0, 1'b0, '0, 1'b0);

        for (int p = 0; p < 6; p++)
        begin
            // Sender pause: every expected result is back before the registers change
            settle();
            wide_targets = 1'b0;
            calm = (p == 2);
            unique case (p)
                0: load_settings(16'd0, 16'd0, 1'b1, -32'sd20, 32'sd20);
                1: load_settings(16'd1, 16'd2, 1'b0, -32'sd50, 32'sd5);
                2: load_settings(16'd2, 16'd1, 1'b1, -32'sd10, 32'sd30);
                3: load_settings(16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
                                 1'($urandom_range(0, 1)), 0 - int'($urandom_range(0, 40)),
                                 $urandom_range(0, 40));
                4: load_settings(16'd1, 16'd1, 1'b1, 32'sd7, 32'sd7);
                default:
                begin
                    // Empty window: every go-to is out of range, so targets can be anything
                    load_settings(16'd0, 16'd3, 1'b1, 32'sd25, -32'sd25);
                    wide_targets = 1'b1;
                end
            endcase
            random_traffic(PHASE_ITEMS);
        end
        calm = 1'b0;

        // Long half period: one step takes many ticks before it completes
        settle();
        load_settings(16'd60, 16'd60, 1'b1, 32'sh80000000, 32'sh7FFFFFFF);
        send_item(ssdp_pkg::CMD_MOVE, 31'd1, 1'b1, '0, 1'b1);
        settle();

        // Longest move the count allows; leave it running
        load_settings(16'd0, 16'hFFFF, 1'b1, 32'sh80000000, 32'sh7FFFFFFF);
        send_item(ssdp_pkg::CMD_MOVE, 31'h7FFFFFFF, 1'b1, '0, 1'b1);
        repeat (40) send_tick(1'($urandom_range(0, 1)));
        send_item(ssdp_pkg::CMD_GOTO, '0, 1'b0, 32'sh80000000, 1'b1);
        send_item(ssdp_pkg::CMD_HOME, '0, 1'b0, '0, 1'b0);

        drain();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && reports_due == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
